[hw/rtl/dldl_pkg.sv]
// Shared types and constants for the dense LDL block factorization engine.
// Used by the top level and by the shared fixed-point divider.
`default_nettype none

package dldl_pkg;

  // Matrix store geometry: addresses wrap inside this depth.
  localparam int ADDR_W      = 10;
  localparam int STORE_DEPTH = 1024;

  // Q16.16 constants and saturation limits.
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Request codes carried in the input beat.
  typedef enum logic [2:0] {
    REQ_LOAD_ENTRY = 3'd0,
    REQ_LOAD_THR   = 3'd1,
    REQ_FACTOR     = 3'd2,
    REQ_READ_ENTRY = 3'd3,
    REQ_READ_DIAG  = 3'd4,
    REQ_READ_THR   = 3'd5,
    REQ_READ_SKIP  = 3'd6,
    REQ_CLEAR_SKIP = 3'd7
  } req_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ROWS  = 3'd0;
  localparam logic [2:0] CFG_COLS  = 3'd1;
  localparam logic [2:0] CFG_FCOL  = 3'd2;
  localparam logic [2:0] CFG_UB    = 3'd3;
  localparam logic [2:0] CFG_GLIM  = 3'd4;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/dense_ldl_block_with_pivot_skip.sv]
// Top level of the dense LDL block factorization engine with pivot skipping.
// Depends on dldl_pkg and the shared divider dldl_div.
//
//  channel | ports                      | contents
//  --------+----------------------------+------------------------------------------
//  in      | in_tvalid/tready/tdata/tuser | request beat: index, value; tuser = req_type
//  out     | out_tvalid/tready/tdata/tuser| result beat: read_value, skip_count; tuser = status
//  cfg     | cfg_psel ... cfg_pready    | APB registers at byte address 4*i
//
// Loads, reads and clear make one store read, then register the result.
// A factor request sweeps the columns through the matrix store, one access per step:
// a read and an evaluate step per scanned entry, a wait for 48 quotient bits per
// divider use, and source read, target read, multiply, write per rank-one update entry.
// Synchronous reset clears the control state only; the stores need no clearing pass.
// A stalled result waits in the output register, and the next request is taken as it leaves.
`default_nettype none

module dense_ldl_block_with_pivot_skip #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 16,
  parameter int MAX_SKIPS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // index[9:0], value[41:10], zero fill
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // read_value[31:0], skip_count[38:32], zero fill
  output      logic [1:0]  out_tuser,  // status[1:0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  localparam int AW  = dldl_pkg::ADDR_W;
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int SW  = $clog2(MAX_SKIPS + 1);
  localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SLW = (MAX_SKIPS > 1) ? $clog2(MAX_SKIPS) : 1;
  localparam int PKW = RW + CW;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_RESP    = 20'h00002,
    S_PIV_RD  = 20'h00004,
    S_PIV_EV  = 20'h00008,
    S_SCAN_RD = 20'h00010,
    S_SCAN_EV = 20'h00020,
    S_UB_DST  = 20'h00040,
    S_UB_DWT  = 20'h00080,
    S_RAISE   = 20'h00100,
    S_DIAG    = 20'h00200,
    S_A_RD    = 20'h00400,
    S_A_DST   = 20'h00800,
    S_A_DWT   = 20'h01000,
    S_J_SRC   = 20'h02000,
    S_J_TGT   = 20'h04000,
    S_J_MUL   = 20'h08000,
    S_J_WR    = 20'h10000,
    S_A_WB    = 20'h20000,
    S_NEXT    = 20'h40000,
    S_DONE    = 20'h80000
  } state_t;

  // Saturate a 33-bit difference to 32 bits.
  function automatic logic signed [31:0] sat33(input logic [32:0] d);
    logic signed [31:0] r;
    if (d[32:31] == 2'b01) begin
      r = dldl_pkg::SAT_MAX;
    end else if (d[32:31] == 2'b10) begin
      r = dldl_pkg::SAT_MIN;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

  // Saturate a 48-bit value to 32 bits.
  function automatic logic signed [31:0] sat48(input logic [47:0] v);
    logic signed [31:0] r;
    if (v[47] && !(&v[46:31])) begin
      r = dldl_pkg::SAT_MIN;
    end else if (!v[47] && (|v[46:31])) begin
      r = dldl_pkg::SAT_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qabs(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == dldl_pkg::SAT_MIN) begin
      r = dldl_pkg::SAT_MAX;
    end else if (v[31]) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [6:0]         rows_r;
  logic [4:0]         cols_r;
  logic [15:0]        fcol_r;
  logic signed [31:0] ub_r;
  logic [30:0]        glim_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd64;
      cols_r <= 5'd16;
      fcol_r <= 16'd0;
      ub_r   <= 32'sd0;
      glim_r <= 31'd65536;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        dldl_pkg::CFG_ROWS: rows_r <= cfg_pwdata[6:0];
        dldl_pkg::CFG_COLS: cols_r <= cfg_pwdata[4:0];
        dldl_pkg::CFG_FCOL: fcol_r <= cfg_pwdata[15:0];
        dldl_pkg::CFG_UB:   ub_r   <= cfg_pwdata;
        dldl_pkg::CFG_GLIM: glim_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      dldl_pkg::CFG_ROWS: cfg_prdata = {25'd0, rows_r};
      dldl_pkg::CFG_COLS: cfg_prdata = {27'd0, cols_r};
      dldl_pkg::CFG_FCOL: cfg_prdata = {16'd0, fcol_r};
      dldl_pkg::CFG_UB:   cfg_prdata = ub_r;
      dldl_pkg::CFG_GLIM: cfg_prdata = {1'b0, glim_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // Effective block shape and packed size.
  logic [RW-1:0]      m_eff;
  logic [CW-1:0]      n_eff;
  logic [PKW-1:0]     packed_sz;
  logic signed [31:0] maxu;

  always_comb begin
    logic [31:0] nt;
    logic [31:0] prod_nm;
    logic [31:0] tri_n;
    if (rows_r == 7'd0) begin
      m_eff = RW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      m_eff = RW'(MAX_ROWS);
    end else begin
      m_eff = RW'(rows_r);
    end
    nt = 32'(cols_r);
    if (nt == 32'd0) begin
      nt = 32'd1;
    end
    if (nt > MAX_COLS) begin
      nt = 32'(MAX_COLS);
    end
    if (nt > 32'(m_eff)) begin
      nt = 32'(m_eff);
    end
    n_eff     = CW'(nt);
    prod_nm   = nt * 32'(m_eff);
    tri_n     = (nt * (nt - 32'd1)) >> 1;
    packed_sz = PKW'(prod_nm - tri_n);
    maxu      = (glim_r == 31'd0) ? 32'sd1 : {1'b0, glim_r};
  end

  // Input beat fields.
  logic [9:0]         in_idx;
  logic signed [31:0] in_val;
  dldl_pkg::req_t     in_req;

  assign in_idx = in_tdata[9:0];
  assign in_val = in_tdata[41:10];
  assign in_req = dldl_pkg::req_t'(in_tuser[2:0]);

  // Control and datapath registers.
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SW-1:0]      skip_total_r, skip_total_nxt;
  dldl_pkg::req_t     req_r, req_nxt;
  logic [9:0]         idx_r, idx_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      nk_r, nk_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [RW-1:0]      len_r, len_nxt;
  logic [RW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [AW-1:0]      sp_r, sp_nxt;
  logic [AW-1:0]      tp_r, tp_nxt;
  logic [AW-1:0]      tgt_r, tgt_nxt;
  logic signed [31:0] xkk_r, xkk_nxt;
  logic signed [31:0] mx_r, mx_nxt;
  logic signed [31:0] ubk_r, ubk_nxt;
  logic signed [31:0] xik_r, xik_nxt;
  logic signed [31:0] src_r, src_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic signed [31:0] out_rv_r, out_rv_nxt;
  logic [6:0]         out_cnt_r, out_cnt_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;

  // Store ports.
  logic               mat_we;
  logic [AW-1:0]      mat_raddr, mat_waddr;
  logic signed [31:0] mat_wdata, mat_rdata;
  logic               thr_we;
  logic [CLW-1:0]     thr_raddr, thr_waddr;
  logic signed [31:0] thr_wdata, thr_rdata;
  logic               diag_we;
  logic [CLW-1:0]     diag_raddr, diag_waddr;
  logic signed [31:0] diag_wdata, diag_rdata;
  logic               skp_we;
  logic [SLW-1:0]     skp_raddr, skp_waddr;
  logic [16:0]        skp_wdata, skp_rdata;

  dldl_pkg::div_req_t div_req;
  dldl_pkg::div_rsp_t div_rsp;

  logic               in_fire;
  logic               do_list;
  logic               ent_ok, col_ok, slot_ok;
  logic signed [31:0] scan_abs;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign ent_ok   = (32'(idx_r) < 32'(packed_sz));
  assign col_ok   = (32'(idx_r) < 32'(n_eff));
  assign slot_ok  = (32'(idx_r) < 32'(skip_total_r)) && (32'(idx_r) < MAX_SKIPS);
  assign scan_abs = qabs(mat_rdata);

  // Sequencer: one matrix-store access per step, so no two of its accesses overlap.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    skip_total_nxt = skip_total_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    k_nxt          = k_r;
    nk_nxt         = nk_r;
    i_nxt          = i_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    sp_nxt         = sp_r;
    tp_nxt         = tp_r;
    tgt_nxt        = tgt_r;
    xkk_nxt        = xkk_r;
    mx_nxt         = mx_r;
    ubk_nxt        = ubk_r;
    xik_nxt        = xik_r;
    src_nxt        = src_r;
    t_nxt          = t_r;
    prod_nxt       = prod_r;
    stat_nxt       = stat_r;
    out_rv_nxt     = out_rv_r;
    out_cnt_nxt    = out_cnt_r;
    out_stat_nxt   = out_stat_r;

    mat_we     = 1'b0;
    mat_raddr  = base_r;
    mat_waddr  = base_r;
    mat_wdata  = val_r;
    thr_we     = 1'b0;
    thr_raddr  = k_r[CLW-1:0];
    thr_waddr  = k_r[CLW-1:0];
    thr_wdata  = val_r;
    diag_we    = 1'b0;
    diag_raddr = in_idx[CLW-1:0];
    diag_waddr = k_r[CLW-1:0];
    diag_wdata = xkk_r;
    skp_we     = 1'b0;
    skp_raddr  = in_idx[SLW-1:0];
    skp_waddr  = skip_total_r[SLW-1:0];
    skp_wdata  = {1'b0, fcol_r} + 17'(k_r);
    div_req.start = 1'b0;
    div_req.a     = mx_r;
    div_req.b     = maxu;
    do_list       = 1'b0;

    case (state_r)
      S_IDLE: begin
        mat_raddr = in_idx;
        thr_raddr = in_idx[CLW-1:0];
        if (in_fire) begin
          req_nxt = in_req;
          idx_nxt = in_idx;
          val_nxt = in_val;
          if (in_req == dldl_pkg::REQ_FACTOR) begin
            k_nxt     = '0;
            nk_nxt    = n_eff;
            len_nxt   = m_eff;
            base_nxt  = '0;
            stat_nxt  = dldl_pkg::STAT_OK;
            state_nxt = S_PIV_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end

      // Single-access requests: read data has arrived, writes land here.
      S_RESP: begin
        out_rv_nxt   = 32'sd0;
        out_stat_nxt = dldl_pkg::STAT_OK;
        mat_waddr    = idx_r;
        thr_waddr    = idx_r[CLW-1:0];
        case (req_r)
          dldl_pkg::REQ_LOAD_ENTRY: begin
            if (ent_ok) mat_we = 1'b1;
            else out_stat_nxt = dldl_pkg::STAT_RANGE;
          end
          dldl_pkg::REQ_LOAD_THR: begin
            if (col_ok) thr_we = 1'b1;
            else out_stat_nxt = dldl_pkg::STAT_RANGE;
          end
          dldl_pkg::REQ_READ_ENTRY: begin
            if (ent_ok) out_rv_nxt = mat_rdata;
            else out_stat_nxt = dldl_pkg::STAT_RANGE;
          end
          dldl_pkg::REQ_READ_DIAG: begin
            if (col_ok) out_rv_nxt = diag_rdata;
            else out_stat_nxt = dldl_pkg::STAT_RANGE;
          end
          dldl_pkg::REQ_READ_THR: begin
            if (col_ok) out_rv_nxt = thr_rdata;
            else out_stat_nxt = dldl_pkg::STAT_RANGE;
          end
          dldl_pkg::REQ_READ_SKIP: begin
            if (slot_ok) out_rv_nxt = {15'd0, skp_rdata};
            else out_stat_nxt = dldl_pkg::STAT_RANGE;
          end
          dldl_pkg::REQ_CLEAR_SKIP: skip_total_nxt = '0;
          default: ;
        endcase
        out_cnt_nxt   = 7'(skip_total_nxt);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_PIV_RD: begin
        mat_raddr = base_r;
        thr_raddr = k_r[CLW-1:0];
        state_nxt = S_PIV_EV;
      end

      // Decide skip, stability check or plain factoring for this pivot.
      S_PIV_EV: begin
        xkk_nxt = mat_rdata;
        if (mat_rdata > thr_rdata) begin
          if (mat_rdata < ub_r) begin
            mx_nxt = 32'sd0;
            if (len_r > RW'(1)) begin
              sp_nxt    = base_r + AW'(1);
              cnt_nxt   = len_r - RW'(1);
              state_nxt = S_SCAN_RD;
            end else begin
              state_nxt = S_UB_DST;
            end
          end else begin
            state_nxt = S_DIAG;
          end
        end else begin
          do_list    = 1'b1;
          diag_we    = 1'b1;
          diag_wdata = 32'sd0;
          state_nxt  = S_NEXT;
        end
      end

      S_SCAN_RD: begin
        mat_raddr = sp_r;
        state_nxt = S_SCAN_EV;
      end

      // Running maximum of the magnitudes below the pivot.
      S_SCAN_EV: begin
        if (scan_abs > mx_r) mx_nxt = scan_abs;
        sp_nxt  = sp_r + AW'(1);
        cnt_nxt = cnt_r - RW'(1);
        state_nxt = (cnt_r == RW'(1)) ? S_UB_DST : S_SCAN_RD;
      end

      S_UB_DST: begin
        div_req.start = 1'b1;
        div_req.a     = mx_r;
        div_req.b     = maxu;
        state_nxt     = S_UB_DWT;
      end

      S_UB_DWT: begin
        if (div_rsp.done) begin
          ubk_nxt   = div_rsp.q;
          state_nxt = S_RAISE;
        end
      end

      // Raise a small pivot, add it to the skip list and keep the added amount as its threshold.
      S_RAISE: begin
        if (xkk_r < ubk_r) begin
          do_list   = 1'b1;
          thr_we    = 1'b1;
          thr_wdata = sat33({ubk_r[31], ubk_r} - {xkk_r[31], xkk_r});
          xkk_nxt   = ubk_r;
        end
        state_nxt = S_DIAG;
      end

      S_DIAG: begin
        diag_we    = 1'b1;
        diag_wdata = xkk_r;
        mat_we     = 1'b1;
        mat_waddr  = base_r;
        mat_wdata  = dldl_pkg::Q_ONE;
        if (nk_r > CW'(1)) begin
          i_nxt     = CW'(1);
          tgt_nxt   = base_r + AW'(len_r);
          state_nxt = S_A_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end

      S_A_RD: begin
        mat_raddr = base_r + AW'(i_r);
        state_nxt = S_A_DST;
      end

      S_A_DST: begin
        div_req.start = 1'b1;
        div_req.a     = mat_rdata;
        div_req.b     = xkk_r;
        state_nxt     = S_A_DWT;
      end

      S_A_DWT: begin
        if (div_rsp.done) begin
          xik_nxt   = div_rsp.q;
          sp_nxt    = base_r + AW'(i_r);
          tp_nxt    = tgt_r;
          cnt_nxt   = len_r - RW'(i_r);
          state_nxt = S_J_SRC;
        end
      end

      // Rank-one update of column k+i, one entry per four steps.
      S_J_SRC: begin
        mat_raddr = sp_r;
        state_nxt = S_J_TGT;
      end

      S_J_TGT: begin
        src_nxt   = mat_rdata;
        mat_raddr = tp_r;
        state_nxt = S_J_MUL;
      end

      S_J_MUL: begin
        t_nxt     = mat_rdata;
        prod_nxt  = $signed(xik_r) * $signed(src_r);
        state_nxt = S_J_WR;
      end

      S_J_WR: begin
        logic signed [31:0] q;
        q         = sat48(prod_r[63:16]);
        mat_we    = 1'b1;
        mat_waddr = tp_r;
        mat_wdata = sat33({t_r[31], t_r} - {q[31], q});
        sp_nxt    = sp_r + AW'(1);
        tp_nxt    = tp_r + AW'(1);
        cnt_nxt   = cnt_r - RW'(1);
        state_nxt = (cnt_r == RW'(1)) ? S_A_WB : S_J_SRC;
      end

      // Store the multiplier and step to the next later column.
      S_A_WB: begin
        mat_we    = 1'b1;
        mat_waddr = base_r + AW'(i_r);
        mat_wdata = xik_r;
        tgt_nxt   = tgt_r + AW'(len_r - RW'(i_r));
        i_nxt     = i_r + CW'(1);
        state_nxt = ((i_r + CW'(1)) < nk_r) ? S_A_RD : S_NEXT;
      end

      S_NEXT: begin
        base_nxt  = base_r + AW'(len_r);
        len_nxt   = len_r - RW'(1);
        k_nxt     = k_r + CW'(1);
        nk_nxt    = nk_r - CW'(1);
        state_nxt = (nk_r == CW'(1)) ? S_DONE : S_PIV_RD;
      end

      S_DONE: begin
        out_rv_nxt    = 32'sd0;
        out_cnt_nxt   = 7'(skip_total_r);
        out_stat_nxt  = stat_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Skip list append; a full list drops the entry and flags the request.
    if (do_list) begin
      if (32'(skip_total_r) < MAX_SKIPS) begin
        skp_we         = 1'b1;
        skip_total_nxt = skip_total_r + SW'(1);
      end else begin
        stat_nxt = dldl_pkg::STAT_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      skip_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      skip_total_r <= skip_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    k_r        <= k_nxt;
    nk_r       <= nk_nxt;
    i_r        <= i_nxt;
    len_r      <= len_nxt;
    cnt_r      <= cnt_nxt;
    base_r     <= base_nxt;
    sp_r       <= sp_nxt;
    tp_r       <= tp_nxt;
    tgt_r      <= tgt_nxt;
    xkk_r      <= xkk_nxt;
    mx_r       <= mx_nxt;
    ubk_r      <= ubk_nxt;
    xik_r      <= xik_nxt;
    src_r      <= src_nxt;
    t_r        <= t_nxt;
    prod_r     <= prod_nxt;
    stat_r     <= stat_nxt;
    out_rv_r   <= out_rv_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // Matrix store, one write and one registered read per cycle.
  logic signed [31:0] mat_mem [dldl_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
    mat_rdata <= mat_mem[mat_raddr];
  end

  // Threshold, diagonal and skip list stores.
  logic signed [31:0] thr_mem  [MAX_COLS];
  logic signed [31:0] diag_mem [MAX_COLS];
  logic [16:0]        skp_mem  [MAX_SKIPS];

  always_ff @(posedge clk) begin
    if (thr_we) thr_mem[thr_waddr] <= thr_wdata;
    thr_rdata <= thr_mem[thr_raddr];
  end

  always_ff @(posedge clk) begin
    if (diag_we) diag_mem[diag_waddr] <= diag_wdata;
    diag_rdata <= diag_mem[diag_raddr];
  end

  always_ff @(posedge clk) begin
    if (skp_we) skp_mem[skp_waddr] <= skp_wdata;
    skp_rdata <= skp_mem[skp_raddr];
  end

  // Shared divider for the raise bound and the multipliers.
  dldl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_rv_r};
  assign out_tuser  = out_stat_r;

  // The sequencer is one-hot and takes requests only when idle.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE))
    else $error("request taken outside idle");

  // Divider results only arrive while the sequencer waits for them.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_UB_DWT || state_r == S_A_DWT))
    else $error("divider result with no waiting step");

  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(skip_total_r) <= MAX_SKIPS)
    else $error("skip count beyond list depth");

  // A new result is only produced into an empty or draining output register.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP || state_r == S_DONE) |-> (!out_valid_r || out_tready))
    else $error("result would overwrite a waiting beat");

endmodule

`default_nettype wire

[hw/rtl/dldl_div.sv]
// Bit-serial Q16.16 divider: q = sat((a * 65536) / b), truncated toward zero.
// Uses dldl_pkg for its request and response types.
`default_nettype none

module dldl_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dldl_pkg::div_req_t req,
  output dldl_pkg::div_rsp_t     rsp
);

  localparam int NW = 48;
  localparam logic [5:0] STEPS = 6'(NW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [NW-1:0]   num_r, num_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     dvs_r, dvs_nxt;
  logic            neg_r, neg_nxt;
  logic            bzero_r, bzero_nxt;
  logic            apos_r, apos_nxt;
  logic            aneg_r, aneg_nxt;

  logic [32:0]     rem_sh;
  logic [32:0]     rem_sub;
  logic            ge;
  logic [31:0]     mag_a;
  logic [31:0]     mag_b;
  logic signed [31:0] q_res;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    mag_a   = req.a[31] ? (~req.a + 32'd1) : req.a;
    mag_b   = req.b[31] ? (~req.b + 32'd1) : req.b;

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    bzero_nxt = bzero_r;
    apos_nxt  = apos_r;
    aneg_nxt  = aneg_r;

    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = STEPS;
      num_nxt   = {mag_a, 16'h0000};
      rem_nxt   = 32'h0;
      dvs_nxt   = mag_b;
      neg_nxt   = req.a[31] ^ req.b[31];
      bzero_nxt = (req.b == 32'sd0);
      apos_nxt  = !req.a[31] && (req.a != 32'sd0);
      aneg_nxt  = req.a[31];
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], ge};
      rem_nxt = ge ? rem_sub[31:0] : rem_sh[31:0];
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Sign, saturation and the zero-divisor cases.
  always_comb begin
    if (bzero_r) begin
      if (apos_r) begin
        q_res = dldl_pkg::SAT_MAX;
      end else if (aneg_r) begin
        q_res = dldl_pkg::SAT_MIN;
      end else begin
        q_res = 32'sd0;
      end
    end else if (neg_r) begin
      if (num_r > 48'h0000_8000_0000) begin
        q_res = dldl_pkg::SAT_MIN;
      end else begin
        q_res = ~num_r[31:0] + 32'd1;
      end
    end else begin
      if (num_r > 48'h0000_7FFF_FFFF) begin
        q_res = dldl_pkg::SAT_MAX;
      end else begin
        q_res = num_r[31:0];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    bzero_r <= bzero_nxt;
    apos_r  <= apos_nxt;
    aneg_r  <= aneg_nxt;
  end

endmodule

`default_nettype wire
